FILE: design/cic_pkg.sv
// Shared types, grid geometry and codes for the cloud-in-cell deposit block.
// Depends on nothing; every other design file imports it.
`default_nettype none

package cic_pkg;

  // Grid geometry (nodes per axis)
  localparam int unsigned GRID_NX    = 16;
  localparam int unsigned GRID_NY    = 16;
  localparam int unsigned GRID_NZ    = 16;
  localparam int unsigned GRID_NODES = GRID_NX * GRID_NY * GRID_NZ;
  localparam int unsigned NODE_AW    = $clog2(GRID_NODES);
  localparam int unsigned IX_W       = $clog2(GRID_NX);
  localparam int unsigned IY_W       = $clog2(GRID_NY);
  localparam int unsigned IZ_W       = $clog2(GRID_NZ);
  localparam int unsigned STRIDE_X   = GRID_NY * GRID_NZ;
  localparam int unsigned STRIDE_Y   = GRID_NZ;

  // Eight corners of a cloud
  localparam int unsigned N_CORNERS  = 8;
  localparam int unsigned CORNER_W   = $clog2(N_CORNERS);

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [23:0] CFG_RESET  = 24'h010000;

  // Configuration register indexes
  localparam int unsigned CFG_IW     = 2;
  localparam logic [CFG_IW-1:0] CFG_INV_CELL_X = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_INV_CELL_Y = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_INV_CELL_Z = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_INV_VOLUME = 2'd3;

  // Actions
  localparam logic ACT_DEPOSIT    = 1'b0;
  localparam logic ACT_READ_CLEAR = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOB = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] weight;
    logic [11:0] node_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] node_value;
    logic [1:0]  status;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load_in;
    logic                scale;
    logic                check;
    logic                issue;
    logic [CORNER_W-1:0] corner;
    logic                rd_issue;
    logic                rd_wb;
    logic                clr_en;
    logic                out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic oob;
    logic busy;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/cic_density_deposit_top.sv
// Top level of the cloud-in-cell density deposit block: controller plus
// datapath. Depends on cic_pkg, cic_ctrl and cic_datapath.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_ready   in_item_t  (deposit or read/clear)
//   out_*        out   out_valid/out_ready out_item_t (value, status)
//   cfg_*        in    cfg_we              cfg_index, cfg_wdata (24 bits)
//
// A deposit runs from accept to the next accept through scale, bounds
// check, eight corner read-modify-writes issued one per cycle through the
// single write port of the grid memory, a drain while the
// three-stage corner pipeline empties, then the result hand-off.
// A read/clear reads, clears, hands off; an out-of-grid deposit skips corners.
// After reset the grid is zeroed one node per cycle (GRID_NODES = 4096
// nodes) with in_ready low; configuration writes are taken meanwhile.
// A finished result sits in the output register; the next item is accepted
// while it waits, and only the hand-off of the following result stalls.
`default_nettype none

module cic_density_deposit_top import cic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [23:0]       cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cic_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // One item at a time: an accepted item closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // Corner pipeline is empty whenever a new item can enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.busy)
    else $error("corner pipeline busy while idle");

  // Corners are only issued for an in-grid deposit
  a_issue_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !stat.oob)
    else $error("corner issued for out-of-grid deposit");

  // Clear pass never overlaps item work
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_ready && !stat.busy && !cmd.rd_wb)
    else $error("clear pass overlaps item work");
`endif

endmodule

`default_nettype wire

FILE: design/cic_ctrl.sv
// Controller FSM for the deposit block: sequences clear pass, scaling,
// corner issue, read/clear and result hand-off. Depends on cic_pkg.
`default_nettype none

module cic_ctrl import cic_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCALE = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_RUN   = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_READ  = 9'b001000000,
    S_RDWB  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CORNER_W-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Next-state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_action == ACT_READ_CLEAR) ? S_READ : S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.oob ? S_DONE : S_RUN;
      end
      S_RUN: begin
        cmd.issue  = 1'b1;
        cmd.corner = cnt_r;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CORNER_W'(N_CORNERS - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.busy) state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RDWB;
      end
      S_RDWB: begin
        cmd.rd_wb = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // output slot free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: design/cic_datapath.sv
// Datapath for the deposit block: config registers, position scaling,
// corner weight pipeline, density grid memory and result register.
// Depends on cic_pkg.
`default_nettype none

module cic_datapath import cic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [23:0]       cfg_wdata,
  input  wire in_item_t          in_data,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output out_item_t              out_data
);

  // Configuration registers
  logic [23:0] inv_x_r, inv_y_r, inv_z_r, inv_vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r   <= CFG_RESET;
      inv_y_r   <= CFG_RESET;
      inv_z_r   <= CFG_RESET;
      inv_vol_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_CELL_X: inv_x_r   <= cfg_wdata;
        CFG_INV_CELL_Y: inv_y_r   <= cfg_wdata;
        CFG_INV_CELL_Z: inv_z_r   <= cfg_wdata;
        CFG_INV_VOLUME: inv_vol_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched item
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_data;
  end

  // Scale positions into cell units: integer part is floor, low 16 bits fraction
  logic [55:0] prod_x, prod_y, prod_z;
  logic [23:0] ix_r, iy_r, iz_r;
  logic [15:0] fx_r, fy_r, fz_r;
  logic [39:0] base_r;

  assign prod_x = 56'(item_r.pos_x) * 56'(inv_x_r);
  assign prod_y = 56'(item_r.pos_y) * 56'(inv_y_r);
  assign prod_z = 56'(item_r.pos_z) * 56'(inv_z_r);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      ix_r   <= prod_x[55:32];
      fx_r   <= prod_x[31:16];
      iy_r   <= prod_y[55:32];
      fy_r   <= prod_y[31:16];
      iz_r   <= prod_z[55:32];
      fz_r   <= prod_z[31:16];
      base_r <= 40'(item_r.weight) * 40'(inv_vol_r);
    end
  end

  // Out-of-grid test: upper node floor+2 must lie inside on every axis
  logic oob;
  assign oob = ((25'(ix_r) + 25'd2) >= 25'(GRID_NX)) ||
               ((25'(iy_r) + 25'd2) >= 25'(GRID_NY)) ||
               ((25'(iz_r) + 25'd2) >= 25'(GRID_NZ));

  // Linear address of the lower corner (floor+1 on each axis)
  logic [NODE_AW-1:0] base_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      base_addr_r <= NODE_AW'(32'(ix_r[IX_W-1:0]) * STRIDE_X
                            + 32'(iy_r[IY_W-1:0]) * STRIDE_Y
                            + 32'(iz_r[IZ_W-1:0]) + STRIDE_X + STRIDE_Y + 1);
    end
  end

  // Corner select: lower node gets 1-f, upper node gets f
  logic [16:0] wx, wy, wz;
  logic [NODE_AW-1:0] corner_addr;

  assign wx = cmd.corner[2] ? {1'b0, fx_r} : ONE_Q16 - {1'b0, fx_r};
  assign wy = cmd.corner[1] ? {1'b0, fy_r} : ONE_Q16 - {1'b0, fy_r};
  assign wz = cmd.corner[0] ? {1'b0, fz_r} : ONE_Q16 - {1'b0, fz_r};
  assign corner_addr = NODE_AW'(32'(base_addr_r)
                              + (cmd.corner[2] ? STRIDE_X : 32'd0)
                              + (cmd.corner[1] ? STRIDE_Y : 32'd0)
                              + 32'(cmd.corner[0]));

  // Corner pipeline: wx*wy, then *wz, then *base, then accumulate
  logic               v1_r, v2_r, v3_r;
  logic [33:0]        prod_xy_r, prod3_r;
  logic [16:0]        wz1_r;
  logic [56:0]        contrib_r;
  logic [NODE_AW-1:0] addr1_r, addr2_r, addr3_r;
  logic [33:0]        rnd_xy, rnd_3;
  logic [16:0]        wxy, w3;

  assign rnd_xy = prod_xy_r + 34'd32768;
  assign wxy    = rnd_xy[32:16];
  assign rnd_3  = prod3_r + 34'd32768;
  assign w3     = rnd_3[32:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_xy_r <= 34'(wx) * 34'(wy);
    wz1_r     <= wz;
    addr1_r   <= corner_addr;
    prod3_r   <= 34'(wxy) * 34'(wz1_r);
    addr2_r   <= addr1_r;
    contrib_r <= 57'(base_r) * 57'(w3);
    addr3_r   <= addr2_r;
  end

  // Accumulate stage: round contribution, clamp, add to node, clamp
  logic [56:0] contrib_rnd;
  logic [32:0] add_full;
  logic        add_sat;
  logic [31:0] add32;
  logic [32:0] sum;
  logic        sum_sat;
  logic [31:0] acc_wdata;
  logic [31:0] mem_q_r;

  assign contrib_rnd = contrib_r + 57'h800000;
  assign add_full    = contrib_rnd[56:24];
  assign add_sat     = add_full[32];
  assign add32       = add_sat ? '1 : add_full[31:0];
  assign sum         = {1'b0, mem_q_r} + {1'b0, add32};
  assign sum_sat     = sum[32];
  assign acc_wdata   = sum_sat ? '1 : sum[31:0];

  logic sat_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in)  sat_r <= 1'b0;
    else if (v3_r)    sat_r <= sat_r | add_sat | sum_sat;
  end

  // Read/clear address
  logic [NODE_AW-1:0] node_addr;
  logic               node_ok;

  assign node_addr = NODE_AW'(item_r.node_address);
  assign node_ok   = 32'(item_r.node_address) < GRID_NODES;

  // Clear pass counter
  logic [NODE_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n)          clr_cnt_r <= '0;
    else if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // Memory port selection
  logic               mem_we, mem_re;
  logic [NODE_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr3_r;
    mem_wdata = acc_wdata;
    if (cmd.clr_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.rd_wb) begin
      mem_we    = node_ok;
      mem_waddr = node_addr;
      mem_wdata = '0;
    end else if (v3_r) begin
      mem_we    = 1'b1;
    end
  end

  assign mem_re    = cmd.rd_issue | v2_r;
  assign mem_raddr = cmd.rd_issue ? node_addr : addr2_r;

  // Density grid: one write and one registered read port
  logic [31:0] grid_mem [GRID_NODES];

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= grid_mem[mem_raddr];
  end

  // Read/clear result
  logic [31:0] rd_value_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_wb) rd_value_r <= node_ok ? mem_q_r : 32'd0;
  end

  // Output register
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (item_r.action == ACT_READ_CLEAR) begin
        out_r.node_value <= rd_value_r;
        out_r.status     <= node_ok ? ST_OK : ST_OOB;
      end else begin
        out_r.node_value <= '0;
        out_r.status     <= oob ? ST_OOB : (sat_r ? ST_SAT : ST_OK);
      end
    end
  end

  assign out_data      = out_r;
  assign stat.oob      = oob;
  assign stat.busy     = v1_r | v2_r | v3_r;
  assign stat.clr_last = (clr_cnt_r == NODE_AW'(GRID_NODES - 1));

endmodule

`default_nettype wire
